>>> sv/ldf_pkg.sv
// Shared types and constants for the link frame deframer.
`default_nettype none

package ldf_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

  localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd4096;
  localparam logic [15:0] HIGHEST_TYPE_RESET = 16'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAGIC        = 2'd0,
    REG_VERSION      = 2'd1,
    REG_MAX_PAYLOAD  = 2'd2,
    REG_HIGHEST_TYPE = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [15:0] frame_type;
    logic [31:0] frame_sequence;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        last_byte;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t item;
  } push_t;

endpackage

`default_nettype wire

>>> sv/ldf_if.sv
// Channel interfaces: received byte stream and delivered frame results.
`default_nettype none

interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ldf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_type;
  logic [31:0] frame_sequence;
  logic [7:0]  data_byte;
  logic        has_data;
  logic        last_byte;

  modport source (output valid, output frame_type, output frame_sequence,
                  output data_byte, output has_data, output last_byte,
                  input ready);
  modport sink   (input valid, input frame_type, input frame_sequence,
                  input data_byte, input has_data, input last_byte,
                  output ready);
endinterface

`default_nettype wire

>>> sv/ldf_front.sv
// Front end: byte intake, header collection and checks, result classification.
`default_nettype none

module ldf_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  ldf_in_if.sink                               rx,
  input  wire logic                            cfg_we,
  input  wire logic [ldf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ldf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            space,
  output ldf_pkg::push_t                       push
);

  logic [31:0] magic_word;
  logic [15:0] version_word;
  logic [15:0] max_payload;
  logic [15:0] highest_type;

  logic [ldf_pkg::HDR_IDX_W-1:0] header_index;
  logic [7:0]  header_bytes [ldf_pkg::HEADER_BYTES-1];
  logic [15:0] payload_left;
  logic        in_payload;
  logic        frame_good;
  logic [15:0] held_type;
  logic [31:0] held_sequence;

  logic        accept;
  logic [31:0] length;
  logic [15:0] hdr_type;
  logic [31:0] hdr_sequence;
  logic [31:0] hdr_magic;
  logic [15:0] hdr_version;
  logic        length_ok;
  logic        hdr_good;
  logic        header_done;

  assign rx.ready = space;
  assign accept   = rx.valid && space;

  assign length       = {rx.rx_byte, header_bytes[14], header_bytes[13], header_bytes[12]};
  assign hdr_magic    = {header_bytes[3], header_bytes[2], header_bytes[1], header_bytes[0]};
  assign hdr_version  = {header_bytes[5], header_bytes[4]};
  assign hdr_type     = {header_bytes[7], header_bytes[6]};
  assign hdr_sequence = {header_bytes[11], header_bytes[10], header_bytes[9], header_bytes[8]};
  assign length_ok    = length <= {16'd0, max_payload};
  assign hdr_good     = (hdr_magic == magic_word) && (hdr_version == version_word) &&
                        (hdr_type <= highest_type);
  assign header_done  = !in_payload && (header_index == ldf_pkg::HDR_LAST);

  always_comb begin
    push.valid               = 1'b0;
    push.item.frame_type     = held_type;
    push.item.frame_sequence = held_sequence;
    push.item.data_byte      = rx.rx_byte;
    push.item.has_data       = 1'b1;
    push.item.last_byte      = (payload_left == 16'd1);
    if (in_payload) begin
      push.valid = accept && frame_good;
    end else if (header_done) begin
      push.item.frame_type     = hdr_type;
      push.item.frame_sequence = hdr_sequence;
      push.item.data_byte      = 8'd0;
      push.item.has_data       = 1'b0;
      push.item.last_byte      = 1'b1;
      push.valid = accept && length_ok && hdr_good && (length[15:0] == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word   <= 32'd0;
      version_word <= 16'd0;
      max_payload  <= ldf_pkg::MAX_PAYLOAD_RESET;
      highest_type <= ldf_pkg::HIGHEST_TYPE_RESET;
    end else if (cfg_we) begin
      case (ldf_pkg::reg_index_t'(cfg_index))
        ldf_pkg::REG_MAGIC:        magic_word   <= cfg_data;
        ldf_pkg::REG_VERSION:      version_word <= cfg_data[15:0];
        ldf_pkg::REG_MAX_PAYLOAD:  max_payload  <= cfg_data[15:0];
        ldf_pkg::REG_HIGHEST_TYPE: highest_type <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_payload && !header_done) begin
      for (int i = 0; i < ldf_pkg::HEADER_BYTES - 1; i++) begin
        if (header_index == ldf_pkg::HDR_IDX_W'(i)) begin
          header_bytes[i] <= rx.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index  <= '0;
      payload_left  <= 16'd0;
      in_payload    <= 1'b0;
      frame_good    <= 1'b0;
      held_type     <= 16'd0;
      held_sequence <= 32'd0;
    end else if (accept) begin
      if (in_payload) begin
        payload_left <= payload_left - 16'd1;
        if (payload_left == 16'd1) begin
          in_payload <= 1'b0;
        end
      end else if (header_done) begin
        header_index <= '0;
        if (length_ok) begin
          held_type     <= hdr_type;
          held_sequence <= hdr_sequence;
          frame_good    <= hdr_good;
          payload_left  <= length[15:0];
          in_payload    <= (length[15:0] != 16'd0);
        end
      end else begin
        header_index <= header_index + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/ldf_queue.sv
// Back end: short result queue that drives the output channel.
`default_nettype none

module ldf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ldf_pkg::push_t push,
  output logic                space,
  ldf_out_if.source           tx
);

  ldf_pkg::result_t mem [ldf_pkg::QUEUE_DEPTH];

  logic [ldf_pkg::QPTR_W-1:0]   head;
  logic [ldf_pkg::QPTR_W-1:0]   tail;
  logic [ldf_pkg::QCOUNT_W-1:0] count;
  logic [ldf_pkg::QCOUNT_W-1:0] count_next;
  logic                         pop;

  assign space = (count != ldf_pkg::QCOUNT_W'(ldf_pkg::QUEUE_DEPTH));
  assign pop   = tx.valid && tx.ready;

  assign tx.valid          = (count != '0);
  assign tx.frame_type     = mem[head].frame_type;
  assign tx.frame_sequence = mem[head].frame_sequence;
  assign tx.data_byte      = mem[head].data_byte;
  assign tx.has_data       = mem[head].has_data;
  assign tx.last_byte      = mem[head].last_byte;

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push.valid) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[tail] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push.valid) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/link_frame_deframer.sv
// Top level of the link frame deframer.
// Throughput: one received byte per cycle, sustained, while the output side takes results.
// Latency: into an empty queue, a result is offered the cycle after the byte causing it.
// The front takes bytes while the four-entry result queue has room.
// Reset (synchronous): queue empty, header collection restarts, registers to their defaults.
`default_nettype none

module link_frame_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  ldf_in_if.sink                               rx,
  ldf_out_if.source                            frames,
  input  wire logic                            cfg_we,
  input  wire logic [ldf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ldf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ldf_pkg::push_t push;
  logic           space;

  ldf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .space     (space),
    .push      (push)
  );

  ldf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (space),
    .tx    (frames)
  );

endmodule

`default_nettype wire

>>> test/tb_link_frame_deframer.sv
// Self-checking testbench for link_frame_deframer: directed frames, then random frame streams.
`timescale 1ns / 100ps

module tb_link_frame_deframer;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1450;
  localparam int PHASE_BYTES  = 300;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, MARKER_ONLY} verdict_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] ftype;
    logic [31:0] seq;
    logic [31:0] length;
    verdict_t    verdict;
  } dir_frame_t;

  // defaults after reset: magic 0, version 0, max payload 4096, highest type 10
  localparam int NUM_DIRECTED = 14;
  dir_frame_t directed_frames [NUM_DIRECTED] = '{
    '{32'h0000_0000, 16'h0000, 16'd0,     32'h0000_0000, 32'd0,         MARKER_ONLY},
    '{32'h0000_0000, 16'h0000, 16'd10,    32'hFFFF_FFFF, 32'd1,         BY_MODEL},
    '{32'h0000_0000, 16'h0000, 16'd11,    32'h0000_0001, 32'd2,         NO_RESULT},
    '{32'h0000_0000, 16'h0000, 16'hFFFF,  32'h0000_0002, 32'd0,         NO_RESULT},
    '{32'h0000_0000, 16'h0000, 16'd3,     32'h1234_5678, 32'd4097,      NO_RESULT},
    '{32'h0000_0000, 16'h0000, 16'd3,     32'h0000_0009, 32'hFFFF_FFFF, NO_RESULT},
    '{32'h0000_0000, 16'h0000, 16'd2,     32'h0000_0010, 32'h0001_0000, NO_RESULT},
    '{32'h0000_0001, 16'h0000, 16'd0,     32'h0000_0005, 32'd1,         NO_RESULT},
    '{32'h8000_0000, 16'h0000, 16'd0,     32'h0000_0006, 32'd0,         NO_RESULT},
    '{32'h0000_0000, 16'h8000, 16'd0,     32'h0000_0007, 32'd2,         NO_RESULT},
    '{32'h0000_0000, 16'h0001, 16'd1,     32'h0000_0008, 32'd0,         NO_RESULT},
    '{32'h0000_0000, 16'h0000, 16'd5,     32'hA5A5_A5A5, 32'd3,         BY_MODEL},
    '{32'h0000_0000, 16'h0000, 16'd10,    32'hFFFF_FFFF, 32'd0,         MARKER_ONLY},
    '{32'h0000_0000, 16'h0000, 16'd0,     32'h0000_0000, 32'd2,         BY_MODEL}
  };

  logic clk;
  logic rst = 1'b1;
  logic                            cfg_we;
  logic [ldf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ldf_pkg::CFG_DATA_W-1:0]  cfg_data;

  ldf_in_if  rx_ch ();
  ldf_out_if res_ch ();

  link_frame_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .frames    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register mirror
  logic [31:0] want_magic   = 32'h0;
  logic [15:0] want_version = 16'h0;
  logic [15:0] max_pay      = ldf_pkg::MAX_PAYLOAD_RESET;
  logic [15:0] top_type     = ldf_pkg::HIGHEST_TYPE_RESET;

  // deframer mirror
  logic [7:0]  hdr_buf [ldf_pkg::HEADER_BYTES];
  int          hdr_fill  = 0;
  logic [15:0] pay_left  = 16'h0;
  bit          in_pay    = 1'b0;
  bit          frame_ok  = 1'b0;
  logic [15:0] cur_type  = 16'h0;
  logic [31:0] cur_seq   = 32'h0;

  ldf_pkg::result_t awaited_results [$];
  bit table_owned = 1'b0;
  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_idle_pct = 24;
  int ready_idle_pct = 24;
  int cycle_count = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int markers_seen = 0;
  int settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // one received byte through the deframer mirror
  task automatic deframe_byte(input logic [7:0] b, output bit made,
                              output ldf_pkg::result_t r);
    logic [31:0] len;
    made = 1'b0;
    r = '0;
    if (in_pay) begin
      pay_left = pay_left - 16'd1;
      if (pay_left == 16'd0) in_pay = 1'b0;
      if (frame_ok) begin
        made = 1'b1;
        r.frame_type     = cur_type;
        r.frame_sequence = cur_seq;
        r.data_byte      = b;
        r.has_data       = 1'b1;
        r.last_byte      = (pay_left == 16'd0);
      end
    end else begin
      hdr_buf[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill == ldf_pkg::HEADER_BYTES) begin
        hdr_fill = 0;
        len = {hdr_buf[15], hdr_buf[14], hdr_buf[13], hdr_buf[12]};
        if (len <= 32'(max_pay)) begin
          cur_type = {hdr_buf[7], hdr_buf[6]};
          cur_seq  = {hdr_buf[11], hdr_buf[10], hdr_buf[9], hdr_buf[8]};
          frame_ok = ({hdr_buf[3], hdr_buf[2], hdr_buf[1], hdr_buf[0]} == want_magic) &&
                     ({hdr_buf[5], hdr_buf[4]} == want_version) &&
                     (cur_type <= top_type);
          pay_left = len[15:0];
          if (pay_left == 16'd0) begin
            if (frame_ok) begin
              made = 1'b1;
              r.frame_type     = cur_type;
              r.frame_sequence = cur_seq;
              r.data_byte      = 8'h00;
              r.has_data       = 1'b0;
              r.last_byte      = 1'b1;
            end
          end else begin
            in_pay = 1'b1;
          end
        end
      end
    end
  endtask

  // sampled mid-cycle, so both sides are settled before the next edge
  always @(negedge clk) begin : watch
    ldf_pkg::result_t got;
    ldf_pkg::result_t want;
    ldf_pkg::result_t fresh;
    bit made;
    in_fire  = !rst && rx_ch.valid && rx_ch.ready;
    out_fire = !rst && res_ch.valid && res_ch.ready;
    if (out_fire) begin
      got.frame_type     = res_ch.frame_type;
      got.frame_sequence = res_ch.frame_sequence;
      got.data_byte      = res_ch.data_byte;
      got.has_data       = res_ch.has_data;
      got.last_byte      = res_ch.last_byte;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result type=%h seq=%h data=%h has=%b last=%b", $time,
                 got.frame_type, got.frame_sequence, got.data_byte, got.has_data,
                 got.last_byte);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (!got.has_data) markers_seen++;
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: expected type=%h seq=%h data=%h has=%b last=%b", $time,
                   want.frame_type, want.frame_sequence, want.data_byte, want.has_data,
                   want.last_byte);
          $display("%0t: actual   type=%h seq=%h data=%h has=%b last=%b", $time,
                   got.frame_type, got.frame_sequence, got.data_byte, got.has_data,
                   got.last_byte);
        end
      end
    end
    if (in_fire) begin
      deframe_byte(rx_ch.rx_byte, made, fresh);
      if (made && !table_owned) awaited_results = {awaited_results, fresh};
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= ready_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < rx_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_fire) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [31:0] m, input logic [15:0] v, input logic [15:0] t,
                            input logic [31:0] s, input logic [31:0] len, input int npay);
    logic [127:0] hdr;
    hdr = {len, s, t, v, m};
    for (int i = 0; i < ldf_pkg::HEADER_BYTES; i++) send_byte(hdr[8*i +: 8]);
    for (int k = 0; k < npay; k++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic wait_drain();
    rx_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] m, input logic [15:0] v,
                              input logic [15:0] mp, input logic [15:0] ht);
    cfg_we    <= 1'b1;
    cfg_index <= ldf_pkg::REG_MAGIC;
    cfg_data  <= m;
    @(posedge clk);
    cfg_index <= ldf_pkg::REG_VERSION;
    cfg_data  <= ($urandom() & 32'hFFFF_0000) | 32'(v);
    @(posedge clk);
    cfg_index <= ldf_pkg::REG_MAX_PAYLOAD;
    cfg_data  <= ($urandom() & 32'hFFFF_0000) | 32'(mp);
    @(posedge clk);
    cfg_index <= ldf_pkg::REG_HIGHEST_TYPE;
    cfg_data  <= ($urandom() & 32'hFFFF_0000) | 32'(ht);
    @(posedge clk);
    cfg_we <= 1'b0;
    want_magic   = m;
    want_version = v;
    max_pay      = mp;
    top_type     = ht;
    settings_used++;
  endtask

  // mostly well-formed frames; the rest bad headers, oversize lengths and torn headers
  task automatic random_frame();
    int pick;
    int cap;
    int lim;
    int cut;
    logic [15:0] t;
    logic [31:0] len;
    logic [127:0] hdr;
    pick = $urandom_range(99);
    cap  = ($urandom_range(9) == 0) ? 40 : 8;
    lim  = (int'(max_pay) < cap) ? int'(max_pay) : cap;
    len  = $urandom_range(lim);
    t    = 16'($urandom_range(32'(top_type)));
    if (pick < 60) begin
      send_frame(want_magic, want_version, t, $urandom(), len, len);
    end else if (pick < 68) begin
      send_frame(want_magic ^ (32'h1 << $urandom_range(31)), want_version, t, $urandom(),
                 len, len);
    end else if (pick < 74) begin
      send_frame(want_magic, want_version ^ (16'h1 << $urandom_range(15)), t, $urandom(),
                 len, len);
    end else if (pick < 80 && top_type != 16'hFFFF) begin
      t = 16'($urandom_range(32'hFFFF, 32'(top_type) + 1));
      send_frame(want_magic, want_version, t, $urandom(), len, len);
    end else if (pick < 88) begin
      len = pick[0] ? 32'(max_pay) + 1 + $urandom_range(1000) : ($urandom() | 32'h0100_0000);
      send_frame(want_magic, want_version, t, $urandom(), len, 0);
    end else begin
      // torn header, realigned by junk whose top length byte forces a drop
      hdr = {len, $urandom(), t, want_version, want_magic};
      cut = $urandom_range(15);
      for (int i = 0; i < cut; i++) send_byte(hdr[8*i +: 8]);
      for (int i = cut; i < ldf_pkg::HEADER_BYTES - 1; i++) send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255, 1)));
    end
  endtask

  initial begin : stimulus
    ldf_pkg::result_t marker;
    dir_frame_t row;
    int phase;
    int phase_start;
    int random_goal;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = ldf_pkg::REG_MAGIC;
    cfg_data      = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_frames[i]) begin
      row = directed_frames[i];
      table_owned = (row.verdict != BY_MODEL);
      if (row.verdict == MARKER_ONLY) begin
        marker.frame_type     = row.ftype;
        marker.frame_sequence = row.seq;
        marker.data_byte      = 8'h00;
        marker.has_data       = 1'b0;
        marker.last_byte      = 1'b1;
        awaited_results = {awaited_results, marker};
      end
      send_frame(row.magic, row.version, row.ftype, row.seq, row.length,
                 (row.length > 32'(max_pay)) ? 0 : int'(row.length));
    end
    table_owned = 1'b0;

    random_goal = bytes_sent + RANDOM_BYTES;
    phase = 0;
    while (bytes_sent < random_goal) begin
      wait_drain();
      rx_idle_pct = 24;
      ready_idle_pct <= 24;
      case (phase)
        0: program_regs($urandom(), 16'($urandom()), ldf_pkg::MAX_PAYLOAD_RESET,
                        ldf_pkg::HIGHEST_TYPE_RESET);
        1: begin
          program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          rx_idle_pct = 0;
          ready_idle_pct <= 0;
        end
        2: program_regs(32'h0, 16'h0, 16'h0, 16'h0);
        default: program_regs($urandom(), 16'($urandom()), 16'($urandom_range(48, 1)),
                              16'($urandom_range(20)));
      endcase
      phase_start = bytes_sent;
      if (phase == 0) begin
        // output held off while a long good frame backs up the block
        hold_req <= 1'b1;
        send_frame(want_magic, want_version, 16'd4, $urandom(), 32'd64, 64);
      end
      while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < random_goal)
        random_frame();
      phase++;
    end

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes over %0d register settings in %0d cycles.",
             bytes_sent, settings_used, cycle_count);
    $display("Checked %0d results, %0d of them empty-frame markers; %0d mismatches.",
             results_checked, markers_seen, mismatch_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ldf_pkg.sv
sv/ldf_if.sv
sv/ldf_front.sv
sv/ldf_queue.sv
sv/link_frame_deframer.sv
test/tb_link_frame_deframer.sv
